### rtl/att_pkg.sv
package att_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int VAL_W = 32;

	localparam logic [1:0] MODE_INSERT   = 2'd0;
	localparam logic [1:0] MODE_TRAVERSE = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;

	localparam logic [1:0] ORDER_IN   = 2'd0;
	localparam logic [1:0] ORDER_PRE  = 2'd1;
	localparam logic [1:0] ORDER_POST = 2'd2;

	localparam logic [1:0] KIND_INSERTED = 2'd0;
	localparam logic [1:0] KIND_FULL     = 2'd1;
	localparam logic [1:0] KIND_VISIT    = 2'd2;
	localparam logic [1:0] KIND_CLEARED  = 2'd3;

	typedef enum logic [3:0] {
		DIR_IDLE  = 4'b0001,
		DIR_DOWN  = 4'b0010,
		DIR_LEFT  = 4'b0100,
		DIR_RIGHT = 4'b1000
	} dir_t;

	typedef struct packed {
		logic             busy;
		logic             emit;
		logic             last;
		logic [IDX_W-1:0] idx;
	} att_walk_t;

endpackage

### rtl/array_tree_traversal_engine.sv
// Array tree traversal engine: values sit in a complete binary tree kept in one
// single-port-write, registered-read RAM (node i has children 2i+1 and 2i+2).
// Insert and clear items each give one result. A traverse of n nodes runs a
// stackless walk sequencer that enters each node, returns from its left subtree
// and returns from its right subtree, one move per cycle unless a visit waits on
// a stalled output, and emits one visited node per RAM read; the next item is
// held off until the final node has been read. Results reach the output through
// one read stage and one output register.
module array_tree_traversal_engine #(
	parameter int CAPACITY = att_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic signed [att_pkg::VAL_W-1:0]  value,
	input  logic [1:0]                        order,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        kind,
	output logic signed [att_pkg::VAL_W-1:0]  node_value,
	output logic [att_pkg::IDX_W-1:0]         node_index,
	output logic                              last
);

	import att_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [CNT_W-1:0] count_q;
	att_walk_t        walk;

	logic             accept;
	logic             full;
	logic             walk_start;
	logic             load_item;
	logic             load_walk;
	logic             s1_adv;
	logic             s1_free;

	logic             ram_we;
	logic             ram_re;
	logic [VAL_W-1:0] ram_rdata;

	logic             v_s1;
	logic             from_ram_s1;
	logic [1:0]       kind_s1;
	logic [VAL_W-1:0] val_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             last_s1;

	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [VAL_W-1:0] value_q;
	logic [IDX_W-1:0] index_q;
	logic             last_q;

	assign s1_adv   = !out_valid_q || out_ready;
	assign s1_free  = !v_s1 || s1_adv;
	assign in_ready = !walk.busy && s1_free;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(CAPACITY));

	assign walk_start = accept && (mode == MODE_TRAVERSE) && (count_q != '0)
		&& (order == ORDER_IN || order == ORDER_PRE || order == ORDER_POST);
	assign load_item  = accept && (mode == MODE_INSERT || mode == MODE_CLEAR);
	assign load_walk  = walk.emit && s1_free;

	assign ram_we = accept && (mode == MODE_INSERT) && !full;
	assign ram_re = load_walk;

	att_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (value),
		.re    (ram_re),
		.raddr (walk.idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	att_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (walk_start),
		.start_order (order),
		.node_count  (count_q),
		.advance     (s1_free),
		.walk        (walk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && mode == MODE_CLEAR) begin
			count_q <= '0;
		end else if (ram_we) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_item || load_walk) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			from_ram_s1 <= 1'b0;
			last_s1     <= 1'b1;
			if (mode == MODE_CLEAR) begin
				kind_s1 <= KIND_CLEARED;
				val_s1  <= '0;
				idx_s1  <= '0;
			end else if (full) begin
				kind_s1 <= KIND_FULL;
				val_s1  <= value;
				idx_s1  <= '0;
			end else begin
				kind_s1 <= KIND_INSERTED;
				val_s1  <= value;
				idx_s1  <= count_q[IDX_W-1:0];
			end
		end else if (load_walk) begin
			from_ram_s1 <= 1'b1;
			last_s1     <= walk.last;
			kind_s1     <= KIND_VISIT;
			val_s1      <= '0;
			idx_s1      <= walk.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && v_s1) begin
			kind_q  <= kind_s1;
			value_q <= from_ram_s1 ? ram_rdata : val_s1;
			index_q <= idx_s1;
			last_q  <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign node_value = value_q;
	assign node_index = index_q;
	assign last       = last_q;

	a_ram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store written and read in one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("node count above capacity");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_adv) |=> (v_s1 && $stable(idx_s1) && $stable(kind_s1)))
		else $error("pending result lost while output stalled");

	a_no_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_start |=> (walk.busy && !in_ready))
		else $error("item taken while traversal runs");

endmodule

### rtl/att_ram.sv
module att_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/att_walker.sv
module att_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  start_order,
	input  logic [att_pkg::CNT_W-1:0]   node_count,
	input  logic                        advance,
	output att_pkg::att_walk_t          walk
);

	import att_pkg::*;

	dir_t             dir_q;
	logic [1:0]       order_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] emitted_q;

	logic [IDX_W+1:0] left_idx;
	logic [IDX_W+1:0] right_idx;
	logic [IDX_W+1:0] cnt_ext;
	logic [IDX_W-1:0] parent_idx;
	logic             busy;
	logic             emit;
	logic             last;
	logic             step;

	assign left_idx   = {1'b0, idx_q, 1'b1};
	assign right_idx  = left_idx + (IDX_W+2)'(1);
	assign cnt_ext    = (IDX_W+2)'(node_count);
	assign parent_idx = (idx_q - IDX_W'(1)) >> 1;
	assign busy       = (dir_q != DIR_IDLE);
	assign last       = (emitted_q == node_count - CNT_W'(1));
	assign step       = busy && (!emit || advance);

	always_comb begin
		case (dir_q)
			DIR_DOWN:  emit = (order_q == ORDER_PRE);
			DIR_LEFT:  emit = (order_q == ORDER_IN);
			DIR_RIGHT: emit = (order_q == ORDER_POST);
			default:   emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q     <= DIR_IDLE;
			order_q   <= ORDER_IN;
			idx_q     <= '0;
			emitted_q <= '0;
		end else if (start) begin
			dir_q     <= DIR_DOWN;
			order_q   <= start_order;
			idx_q     <= '0;
			emitted_q <= '0;
		end else if (step) begin
			if (emit) begin
				emitted_q <= emitted_q + CNT_W'(1);
			end
			if (emit && last) begin
				dir_q <= DIR_IDLE;
			end else begin
				case (dir_q)
					DIR_DOWN: begin
						if (left_idx < cnt_ext) begin
							idx_q <= left_idx[IDX_W-1:0];
						end else begin
							dir_q <= DIR_LEFT;
						end
					end
					DIR_LEFT: begin
						if (right_idx < cnt_ext) begin
							idx_q <= right_idx[IDX_W-1:0];
							dir_q <= DIR_DOWN;
						end else begin
							dir_q <= DIR_RIGHT;
						end
					end
					DIR_RIGHT: begin
						idx_q <= parent_idx;
						dir_q <= idx_q[0] ? DIR_LEFT : DIR_RIGHT;
					end
					default: dir_q <= DIR_IDLE;
				endcase
			end
		end
	end

	assign walk.busy = busy;
	assign walk.emit = emit;
	assign walk.last = last;
	assign walk.idx  = idx_q;

	a_node_present: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ((IDX_W+2)'(idx_q) < cnt_ext))
		else $error("walker on absent node");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (emitted_q < node_count))
		else $error("walker emitted more nodes than stored");

	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last && advance && !start) |=> !busy)
		else $error("walker kept running after final node");

endmodule

### tb/array_tree_traversal_engine_tb.sv
`timescale 1ns / 1ps

module array_tree_traversal_engine_tb;
	import att_pkg::*;

	localparam int TREE_CAP = CAPACITY_DEF;
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam logic [1:0] ORDER_NONE = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_AT = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 310;
	localparam int CALM_AFTER = 270;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [1:0]       kind;
		logic [VAL_W-1:0] val;
		logic [IDX_W-1:0] idx;
		logic             lst;
	} node_result_t;

	class tree_scoreboard;
		logic [VAL_W-1:0] tree_vals [TREE_CAP];
		int unsigned tree_size;
		node_result_t exp_q[$];
		int errors;

		function new();
			tree_size = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		function void push_result(logic [1:0] k, logic [VAL_W-1:0] v, int unsigned i, logic l);
			node_result_t r;
			r.kind = k;
			r.val = v;
			r.idx = i[IDX_W-1:0];
			r.lst = l;
			exp_q.push_back(r);
		endfunction

		function void visit_subtree(int unsigned i, logic [1:0] ord);
			if (i >= tree_size)
				return;
			if (ord == ORDER_PRE)
				push_result(KIND_VISIT, tree_vals[i], i, 1'b0);
			visit_subtree(2 * i + 1, ord);
			if (ord == ORDER_IN)
				push_result(KIND_VISIT, tree_vals[i], i, 1'b0);
			visit_subtree(2 * i + 2, ord);
			if (ord == ORDER_POST)
				push_result(KIND_VISIT, tree_vals[i], i, 1'b0);
		endfunction

		function void note_input(logic [1:0] m, logic [VAL_W-1:0] v, logic [1:0] o);
			int unsigned n0;
			case (m)
				MODE_INSERT: begin
					if (tree_size >= TREE_CAP) begin
						push_result(KIND_FULL, v, 0, 1'b1);
					end else begin
						tree_vals[tree_size] = v;
						push_result(KIND_INSERTED, v, tree_size, 1'b1);
						tree_size++;
					end
				end
				MODE_TRAVERSE: begin
					if (o != ORDER_NONE && tree_size != 0) begin
						n0 = exp_q.size();
						visit_subtree(0, o);
						if (exp_q.size() > n0)
							exp_q[exp_q.size() - 1].lst = 1'b1;
					end
				end
				MODE_CLEAR: begin
					tree_size = 0;
					push_result(KIND_CLEARED, '0, 0, 1'b1);
				end
				default: begin
				end
			endcase
		endfunction

		task check_result(logic [1:0] k, logic [VAL_W-1:0] v, logic [IDX_W-1:0] i, logic l);
			node_result_t e;
			if (exp_q.size() == 0) begin
				report($sformatf("unexpected result kind=%0d value=%h index=%0d last=%0b",
					k, v, i, l));
				return;
			end
			e = exp_q.pop_front();
			if (k !== e.kind || v !== e.val || i !== e.idx || l !== e.lst)
				report($sformatf("got kind=%0d value=%h index=%0d last=%0b, exp %0d %h %0d %0b",
					k, v, i, l, e.kind, e.val, e.idx, e.lst));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = '0;
	logic [VAL_W-1:0] value = '0;
	logic [1:0] order = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [VAL_W-1:0] node_value;
	logic [IDX_W-1:0] node_index;
	logic last;

	tree_scoreboard sb;
	int n_sent = 0;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_done = 1'b0;

	array_tree_traversal_engine #(
		.CAPACITY(TREE_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.value(value),
		.order(order),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.node_value(node_value),
		.node_index(node_index),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_item(input logic [1:0] m, input logic [VAL_W-1:0] v, input logic [1:0] o);
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		order <= o;
		do @(posedge clk); while (!in_ready);
		sb.note_input(m, v, o);
		n_sent++;
		if (n_sent >= CALM_AFTER)
			no_idle = 1'b1;
	endtask

	task automatic fill_tree();
		while (sb.tree_size < TREE_CAP)
			send_item(MODE_INSERT, rand_value(), 2'($urandom_range(0, 3)));
		repeat ($urandom_range(1, 3))
			send_item(MODE_INSERT, rand_value(), 2'($urandom_range(0, 3)));
		send_item(MODE_TRAVERSE, $urandom(), 2'($urandom_range(0, 2)));
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(kind, node_value, node_index, last);
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && n_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		int seq;
		sb = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		send_item(MODE_TRAVERSE, $urandom(), ORDER_IN);
		send_item(MODE_CLEAR, $urandom(), 2'($urandom_range(0, 3)));
		send_item(MODE_INSERT, 32'h8000_0000, ORDER_IN);
		send_item(MODE_INSERT, 32'h7fff_ffff, ORDER_PRE);
		send_item(MODE_INSERT, 32'h0000_0000, ORDER_POST);
		send_item(MODE_INSERT, 32'hffff_ffff, ORDER_NONE);
		send_item(MODE_INSERT, 32'h5555_5555, ORDER_IN);
		send_item(MODE_INSERT, 32'haaaa_aaaa, ORDER_NONE);
		send_item(MODE_TRAVERSE, 32'hffff_ffff, ORDER_IN);
		send_item(MODE_TRAVERSE, 32'h0000_0000, ORDER_PRE);
		send_item(MODE_TRAVERSE, $urandom(), ORDER_POST);
		send_item(MODE_TRAVERSE, $urandom(), ORDER_NONE);
		send_item(MODE_NONE, 32'hffff_ffff, ORDER_NONE);
		send_item(MODE_NONE, 32'h0000_0000, ORDER_IN);
		send_item(MODE_INSERT, 32'h0000_0001, ORDER_IN);
		send_item(MODE_TRAVERSE, $urandom(), ORDER_IN);
		send_item(MODE_CLEAR, 32'hffff_ffff, ORDER_NONE);
		send_item(MODE_TRAVERSE, $urandom(), ORDER_PRE);
		send_item(MODE_INSERT, 32'h0000_002a, ORDER_IN);
		send_item(MODE_TRAVERSE, $urandom(), ORDER_POST);
		send_item(MODE_CLEAR, $urandom(), ORDER_IN);

		// full store and reject path first, under receiver hold-off
		fill_tree();
		send_item(MODE_TRAVERSE, $urandom(), ORDER_IN);
		send_item(MODE_TRAVERSE, $urandom(), ORDER_PRE);
		send_item(MODE_CLEAR, $urandom(), 2'($urandom_range(0, 3)));

		while (n_sent < ITEM_TARGET) begin
			seq = $urandom_range(0, 29);
			if (seq < 18) begin
				repeat ($urandom_range(1, 8))
					send_item(MODE_INSERT, rand_value(), 2'($urandom_range(0, 3)));
				send_item(MODE_TRAVERSE, $urandom(), 2'($urandom_range(0, 2)));
				if ($urandom_range(0, 3) == 0)
					send_item(MODE_TRAVERSE, $urandom(), 2'($urandom_range(0, 2)));
			end else if (seq < 24) begin
				send_item(MODE_CLEAR, $urandom(), 2'($urandom_range(0, 3)));
			end else if (seq == 24) begin
				fill_tree();
			end else if (seq < 27) begin
				send_item(MODE_TRAVERSE, $urandom(), ORDER_NONE);
			end else begin
				send_item(2'($urandom_range(0, 3)), rand_value(), 2'($urandom_range(0, 3)));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.exp_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.exp_q.size()));
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
rtl/att_pkg.sv
rtl/att_ram.sv
rtl/att_walker.sv
rtl/array_tree_traversal_engine.sv
tb/array_tree_traversal_engine_tb.sv
